/* design/ilie_pkg.sv */
package ilie_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int POS_W        = 5;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;

    typedef enum logic [1:0] {
        MODE_READ      = 2'd0,
        MODE_OVERWRITE = 2'd1,
        MODE_INSERT    = 2'd2,
        MODE_ERASE     = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What a cell loads on the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_PREV = 2'd2,
        CELL_NEXT = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

/* design/indexed_list_insert_erase.sv */
// Bounded ordered list of signed 32-bit elements, held in a row of cells where
// cell i always holds list element i.
//
// Input channel (in_valid / in_stall): one transfer carries mode, position and
// value. Read returns the element at position, overwrite replaces it, insert
// places value before position (position may equal the count to append) and
// erase removes the element at position. Insert and erase move every later
// element one cell up or down at once, each cell taking its neighbor's data.
//
// Output channel (out_valid / out_stall): one result transfer per input
// transfer, with read_value, status, count and is_empty, in order.
//
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle, set by the single output register: a new item is taken
// whenever that register is empty or being emptied. When the receiver stalls,
// the result holds and in_stall rises until it is taken. Reset empties the
// list and the output register; element cells keep whatever they held, since
// nothing outside the list is ever read.
module indexed_list_insert_erase
    import ilie_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               mode,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] read_value,
    output logic [STATUS_W-1:0]      status,
    output logic [CNT_W-1:0]         count,
    output logic                     is_empty
);

    // Common width for comparing the position against counts and cell indexes.
    localparam int CW = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] read_value_reg;
    logic signed [DATA_W-1:0] read_value_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     is_empty_reg;
    logic                     is_empty_next;
    logic [CNT_W-1:0]         occupancy_reg;
    logic [CNT_W-1:0]         occupancy_next;

    logic                     accept;
    mode_t                    op_mode;
    logic [CW-1:0]            pos_w;
    logic [CW-1:0]            occ_w;
    logic                     full;
    logic                     op_ok;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    // The output register frees up in the same cycle it is taken.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign op_mode  = mode_t'(mode);
    assign pos_w    = CW'(position);
    assign occ_w    = CW'(occupancy_reg);
    assign full     = (occupancy_reg == CNT_W'(CAPACITY));

    // Range and capacity checks; the range test wins over the full test.
    always_comb
    begin
        status_next = ST_DONE;
        case (op_mode)
            MODE_INSERT:
            begin
                if (pos_w > occ_w)
                    status_next = ST_RANGE;
                else if (full)
                    status_next = ST_FULL;
            end
            default:
            begin
                if (pos_w >= occ_w)
                    status_next = ST_RANGE;
            end
        endcase
        op_ok = (status_next == ST_DONE);
    end

    // Per-cell control: each cell decides from its own index which neighbor,
    // if any, it takes data from.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic signed [DATA_W-1:0] prev_d;
        logic signed [DATA_W-1:0] next_d;
        cell_ctrl_t               ctrl_c;

        always_comb
        begin
            ctrl_c.op = CELL_HOLD;
            if (accept && op_ok)
            begin
                case (op_mode)
                    MODE_OVERWRITE:
                    begin
                        if (IDX == pos_w)
                            ctrl_c.op = CELL_LOAD;
                    end
                    MODE_INSERT:
                    begin
                        if (IDX == pos_w)
                            ctrl_c.op = CELL_LOAD;
                        else if (IDX > pos_w)
                            ctrl_c.op = CELL_PREV;
                    end
                    MODE_ERASE:
                    begin
                        if (IDX >= pos_w)
                            ctrl_c.op = CELL_NEXT;
                    end
                    default:
                    begin
                        ctrl_c.op = CELL_HOLD;
                    end
                endcase
            end
        end

        if (i == 0)
        begin : g_first
            assign prev_d = '0;
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_d = '0;
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[i+1];
        end

        ilie_cell u_cell
        (
            .clk       (clk),
            .ctrl      (ctrl_c),
            .load_data (value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i])
        );
    end

    // Result and count update. An in-range position is always below CAPACITY,
    // so its low bits index the cell row directly.
    always_comb
    begin
        occupancy_next  = occupancy_reg;
        read_value_next = read_value_reg;
        count_next      = count_reg;
        is_empty_next   = is_empty_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (accept)
        begin
            read_value_next = '0;
            if (op_ok)
            begin
                case (op_mode)
                    MODE_READ:   read_value_next = cell_data[pos_w[IW-1:0]];
                    MODE_INSERT: occupancy_next  = occupancy_reg + CNT_W'(1);
                    MODE_ERASE:  occupancy_next  = occupancy_reg - CNT_W'(1);
                    default:     occupancy_next  = occupancy_reg;
                endcase
            end
            count_next     = occupancy_next;
            is_empty_next  = (occupancy_next == '0);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occupancy_reg <= occupancy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        count_reg      <= count_next;
        is_empty_reg   <= is_empty_next;
        if (accept)
            status_reg <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = count_reg;
    assign is_empty   = is_empty_reg;

endmodule

/* design/ilie_cell.sv */
module ilie_cell
    import ilie_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] load_data,
    input  logic signed [DATA_W-1:0] prev_data,
    input  logic signed [DATA_W-1:0] next_data,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // The element store has no reset; only cells inside the list are read.
    always_comb
    begin
        case (ctrl.op)
            CELL_HOLD: data_next = data_reg;
            CELL_LOAD: data_next = load_data;
            CELL_PREV: data_next = prev_data;
            CELL_NEXT: data_next = next_data;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
